// ----- rtl/cedu_pkg.sv -----
// ----------------------------------------------------------------------------
// cedu_pkg
// Types, character codes and helpers shared by the command escape decoder.
// ----------------------------------------------------------------------------
package cedu_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX0  = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_OCT   = 3'd4,
    MODE_DELAY = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_END   = 3'd1,
    KIND_DELAY = 3'd2,
    KIND_SEND  = 3'd3,
    KIND_WAIT  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [7:0]  char_value;
    logic [31:0] delay_ms;
    logic        last;
  } result_t;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_7         = 8'h37;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LB        = 8'h62;
  localparam logic [7:0] CH_LD        = 8'h64;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_LM        = 8'h6d;
  localparam logic [7:0] CH_LN        = 8'h6e;
  localparam logic [7:0] CH_LR        = 8'h72;
  localparam logic [7:0] CH_LS        = 8'h73;
  localparam logic [7:0] CH_LT        = 8'h74;
  localparam logic [7:0] CH_LV        = 8'h76;
  localparam logic [7:0] CH_LW        = 8'h77;
  localparam logic [7:0] CH_LX        = 8'h78;

  localparam logic [7:0] CODE_ALERT = 8'd7;
  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_LF    = 8'd10;
  localparam logic [7:0] CODE_VT    = 8'd11;
  localparam logic [7:0] CODE_FF    = 8'd12;
  localparam logic [7:0] CODE_CR    = 8'd13;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- rtl/command_escape_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// command_escape_decoder_unit
// Decodes modem command string bytes with backslash escapes into tokens.
// ----------------------------------------------------------------------------
// Input stream s_*: one command byte per transaction, zero ends the string.
// Output stream m_*: one token per transaction (character, end of string,
// delay, send marker or wait); m_tlast marks the final token of one byte.
// A byte lands in an input register, is decoded in one pass against the
// escape state, and its zero, one or two tokens load a two-entry output
// queue. Throughput is one byte per cycle while m_tready stays high and
// each byte gives at most one token; a byte that closes a hex, octal or
// delay escape by lookahead and also yields its own token holds the next
// byte back until the single output port has drained the queue. A byte is
// decoded only when the queue empties in that cycle. When m_tready is low
// the queue holds, the input register keeps one byte, and s_tready drops.
// Reset empties both and returns the decoder to plain text mode.
// DELAY_WIDTH sets the delay accumulator width; delays saturate at its
// maximum and the low 32 bits are reported.
// ----------------------------------------------------------------------------
module command_escape_decoder_unit #(
  parameter int unsigned DELAY_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cedu_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] ch
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cedu_pkg::OUT_TDATA_W-1:0] m_tdata,   // [2:0] token_kind,
                                                      // [10:3] char_value,
                                                      // [42:11] delay_ms
  output logic                             m_tlast
);
  import cedu_pkg::*;

  localparam int unsigned W = DELAY_WIDTH;

  logic                in_valid;
  logic [7:0]          in_ch;
  mode_t               mode, mode_next;
  logic [8:0]          digit_accum, digit_accum_next;
  logic [1:0]          digit_count, digit_count_next;
  logic [W-1:0]        delay_accum, delay_accum_next;
  logic                delay_is_wait, delay_is_wait_next;
  result_t             q0, q1;
  logic [1:0]          cnt;

  logic                pop, advance;
  logic [1:0]          cnt_after;
  logic                is_oct, is_dec, hex_ok;
  logic [3:0]          hex_val;
  logic                idle_has;
  mode_t               idle_mode;
  result_t             idle_res;
  result_t             r0, r1;
  logic                has0, has1;
  logic [W+3:0]        prod10;
  logic [W-1:0]        delay_inc;
  logic [W-1:0]        t_ms;
  logic [W+9:0]        prod1000;
  logic [W-1:0]        t_sec;
  logic [W+31:0]       t_ext;
  logic [W-1:0]        t_out;

  // ---------------- handshake ----------------
  assign m_tvalid  = (cnt != 2'd0);
  assign pop       = m_tvalid && m_tready;
  assign cnt_after = cnt - {1'b0, pop};
  assign advance   = in_valid && (cnt_after == 2'd0);
  assign s_tready  = !in_valid || advance;

  assign m_tdata = {5'd0, q0.delay_ms, q0.char_value, q0.token_kind};
  assign m_tlast = q0.last;

  // ---------------- byte classes and arithmetic ----------------
  assign is_oct  = (in_ch >= CH_0) && (in_ch <= CH_7);
  assign is_dec  = (in_ch >= CH_0) && (in_ch <= CH_9);
  assign {hex_ok, hex_val} = hex_digit(in_ch);

  assign prod10    = ({4'd0, delay_accum} << 3) + ({4'd0, delay_accum} << 1)
                   + {{W{1'b0}}, in_ch[3:0]};
  assign delay_inc = (prod10[W+3:W] != 4'd0) ? {W{1'b1}} : prod10[W-1:0];

  assign t_ms      = (delay_accum == '0) ? {{(W-1){1'b0}}, 1'b1} : delay_accum;
  assign prod1000  = ({10'd0, t_ms} << 10) - ({10'd0, t_ms} << 4) - ({10'd0, t_ms} << 3);
  assign t_sec     = (prod1000[W+9:W] != 10'd0) ? {W{1'b1}} : prod1000[W-1:0];
  assign t_out     = (in_ch == CH_LM) ? t_ms : t_sec;
  assign t_ext     = {32'd0, t_out};

  // byte handled as plain text
  always_comb begin
    idle_has             = (in_ch != CH_BACKSLASH);
    idle_mode            = (in_ch == CH_BACKSLASH) ? MODE_ESC : MODE_IDLE;
    idle_res.token_kind  = (in_ch == CH_NUL) ? KIND_END : KIND_CHAR;
    idle_res.char_value  = in_ch;
    idle_res.delay_ms    = 32'd0;
    idle_res.last        = 1'b0;
  end

  // ---------------- next state ----------------
  always_comb begin
    mode_next          = mode;
    digit_accum_next   = digit_accum;
    digit_count_next   = digit_count;
    delay_accum_next   = delay_accum;
    delay_is_wait_next = delay_is_wait;
    case (mode)
      MODE_IDLE: begin
        mode_next = idle_mode;
      end
      MODE_ESC: begin
        mode_next = MODE_IDLE;
        priority if (in_ch == CH_LX) begin
          mode_next = MODE_HEX0;
        end else if (in_ch == CH_LD || in_ch == CH_LW) begin
          mode_next          = MODE_DELAY;
          delay_accum_next   = '0;
          delay_is_wait_next = (in_ch == CH_LW);
        end else if (is_oct) begin
          mode_next        = MODE_OCT;
          digit_accum_next = {6'd0, in_ch[2:0]};
          digit_count_next = 2'd1;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_HEX0: begin
        if (hex_ok) begin
          mode_next        = MODE_HEX1;
          digit_accum_next = {5'd0, hex_val};
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_HEX1: begin
        mode_next = hex_ok ? MODE_IDLE : idle_mode;
      end
      MODE_OCT: begin
        if (is_oct) begin
          digit_accum_next = {digit_accum[5:0], in_ch[2:0]};
          digit_count_next = digit_count + 2'd1;
          if (digit_count == 2'd2) begin
            mode_next = MODE_IDLE;
          end
        end else begin
          mode_next = idle_mode;
        end
      end
      MODE_DELAY: begin
        if (is_dec) begin
          delay_accum_next = delay_inc;
        end else if (in_ch == CH_LM || in_ch == CH_LS) begin
          mode_next = MODE_IDLE;
        end else begin
          mode_next = idle_mode;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  // ---------------- results ----------------
  always_comb begin
    r0            = idle_res;
    r1            = idle_res;
    has0          = 1'b0;
    has1          = 1'b0;
    case (mode)
      MODE_IDLE: begin
        has0 = idle_has;
      end
      MODE_ESC: begin
        has0 = 1'b1;
        r0.token_kind = KIND_CHAR;
        unique case (in_ch)
          CH_NUL: r0.token_kind = KIND_END;
          CH_LA:  r0.char_value = CODE_ALERT;
          CH_LB:  r0.char_value = CODE_BS;
          CH_LF:  r0.char_value = CODE_FF;
          CH_LN:  r0.char_value = CODE_LF;
          CH_LR:  r0.char_value = CODE_CR;
          CH_LT:  r0.char_value = CODE_TAB;
          CH_LV:  r0.char_value = CODE_VT;
          CH_LS: begin
            r0.token_kind = KIND_SEND;
            r0.char_value = 8'd0;
          end
          CH_LX, CH_LD, CH_LW: has0 = 1'b0;
          default: has0 = !is_oct;
        endcase
      end
      MODE_HEX0: begin
        has0 = !hex_ok;
      end
      MODE_HEX1: begin
        has0          = 1'b1;
        r0.token_kind = KIND_CHAR;
        r0.char_value = hex_ok ? {digit_accum[3:0], hex_val} : digit_accum[7:0];
        has1          = !hex_ok && idle_has;
      end
      MODE_OCT: begin
        r0.token_kind = KIND_CHAR;
        if (is_oct) begin
          has0          = (digit_count == 2'd2);
          r0.char_value = {digit_accum[4:0], in_ch[2:0]};
        end else begin
          has0          = 1'b1;
          r0.char_value = digit_accum[7:0];
          has1          = idle_has;
        end
      end
      MODE_DELAY: begin
        has0          = !is_dec;
        r0.token_kind = delay_is_wait ? KIND_WAIT : KIND_DELAY;
        r0.char_value = 8'd0;
        r0.delay_ms   = t_ext[31:0];
        has1          = !is_dec && (in_ch != CH_LM) && (in_ch != CH_LS) && idle_has;
      end
      default: begin
        has0 = 1'b0;
      end
    endcase
    r0.last = !has1;
    r1.last = 1'b1;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      mode          <= MODE_IDLE;
      digit_accum   <= '0;
      digit_count   <= '0;
      delay_accum   <= '0;
      delay_is_wait <= 1'b0;
      cnt           <= 2'd0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        mode          <= mode_next;
        digit_accum   <= digit_accum_next;
        digit_count   <= digit_count_next;
        delay_accum   <= delay_accum_next;
        delay_is_wait <= delay_is_wait_next;
        cnt           <= {1'b0, has0} + {1'b0, has1};
      end else if (pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch <= s_tdata;
    end
    if (advance) begin
      q0 <= r0;
      q1 <= r1;
    end else if (pop) begin
      q0 <= q1;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for command_escape_decoder_unit. A short table of
// command bytes walks through plain text, end of string, the named escapes,
// hex, octal, delay and wait escapes and the lookahead terminators. Random
// command strings built from well-formed escapes plus noise follow. Every
// accepted byte runs through a local token decoder and each output
// transaction is compared field by field with the oldest expected token.
// The sender works in bursts and the receiver stalls, once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import cedu_pkg::*;

  localparam int unsigned DIR_N       = 28;
  localparam int unsigned RAND_ITEMS  = 1550;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [63:0] DLY_MAX     = 64'hffff_ffff;

  typedef struct packed {
    logic [7:0]  ch;
    logic        typed;  // expected token given in the row
    kind_t       kind;
    logic [7:0]  cv;
    logic [31:0] dl;
  } cmd_row_t;

  localparam cmd_row_t DIR_TAB [DIR_N] = '{
    '{CH_UA,        1'b1, KIND_CHAR,  CH_UA,      32'd0},
    '{8'hff,        1'b1, KIND_CHAR,  8'hff,      32'd0},
    '{CH_NUL,       1'b1, KIND_END,   8'd0,       32'd0},
    '{CH_BACKSLASH, 1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LA,        1'b1, KIND_CHAR,  CODE_ALERT, 32'd0},
    '{CH_BACKSLASH, 1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LS,        1'b1, KIND_SEND,  8'd0,       32'd0},
    '{CH_BACKSLASH, 1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LX,        1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_UF,        1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LF,        1'b1, KIND_CHAR,  8'hff,      32'd0},
    '{CH_BACKSLASH, 1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_7,         1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_7,         1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_7,         1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_BACKSLASH, 1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LW,        1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LM,        1'b1, KIND_WAIT,  8'd0,       32'd1},
    '{CH_BACKSLASH, 1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LD,        1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{"5",          1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_UA,        1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_BACKSLASH, 1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LX,        1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_NUL,       1'b1, KIND_END,   8'd0,       32'd0},
    '{CH_BACKSLASH, 1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{CH_LX,        1'b0, KIND_CHAR,  8'd0,       32'd0},
    '{"g",          1'b1, KIND_CHAR,  "g",        32'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [7:0] ch
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [2:0] token_kind, [10:3] char_value,
                                     // [42:11] delay_ms
  logic                   m_tlast;

  command_escape_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state mirror
  mode_t       esc_state = MODE_IDLE;
  logic [8:0]  dig_val = '0;
  logic [1:0]  oct_count = '0;
  logic [63:0] dly_val = '0;
  logic        dly_wait = 1'b0;

  cmd_row_t    plan[$];
  result_t     fresh[$];
  result_t     tokens_due[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned kind_seen [5] = '{0, 0, 0, 0, 0};
  int unsigned sat_delays = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  string HEX_CHARS = "0123456789abcdefABCDEF";
  string ESC_CHARS = "abfnrtvs";

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic logic [63:0] clip_mul(input logic [63:0] a, input logic [63:0] m);
    if (a > DLY_MAX / m) return DLY_MAX;
    return a * m;
  endfunction

  function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] d);
    if (a > DLY_MAX - d) return DLY_MAX;
    return a + d;
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  task automatic push_token(input kind_t k, input logic [7:0] cv, input logic [63:0] dl);
    result_t t;
    t.token_kind = k;
    t.char_value = cv;
    t.delay_ms   = dl[31:0];
    t.last       = 1'b0;
    fresh.push_back(t);
  endtask

  // byte seen outside any escape
  task automatic plain_byte(input logic [7:0] c);
    if (c == CH_NUL) begin
      esc_state = MODE_IDLE;
      push_token(KIND_END, 8'd0, 64'd0);
    end else if (c == CH_BACKSLASH) begin
      esc_state = MODE_ESC;
    end else begin
      esc_state = MODE_IDLE;
      push_token(KIND_CHAR, c, 64'd0);
    end
  endtask

  task automatic decode_byte(input logic [7:0] c);
    int          h;
    logic [63:0] t;
    kind_t       k;
    fresh.delete();
    h = nibble_of(c);
    case (esc_state)
      MODE_ESC: begin
        esc_state = MODE_IDLE;
        case (c)
          CH_NUL: push_token(KIND_END, 8'd0, 64'd0);
          CH_LA:  push_token(KIND_CHAR, CODE_ALERT, 64'd0);
          CH_LB:  push_token(KIND_CHAR, CODE_BS, 64'd0);
          CH_LF:  push_token(KIND_CHAR, CODE_FF, 64'd0);
          CH_LN:  push_token(KIND_CHAR, CODE_LF, 64'd0);
          CH_LR:  push_token(KIND_CHAR, CODE_CR, 64'd0);
          CH_LT:  push_token(KIND_CHAR, CODE_TAB, 64'd0);
          CH_LV:  push_token(KIND_CHAR, CODE_VT, 64'd0);
          CH_LS:  push_token(KIND_SEND, 8'd0, 64'd0);
          CH_LX:  esc_state = MODE_HEX0;
          CH_LD, CH_LW: begin
            esc_state = MODE_DELAY;
            dly_val   = '0;
            dly_wait  = (c == CH_LW);
          end
          default: begin
            if (c >= CH_0 && c <= CH_7) begin
              esc_state = MODE_OCT;
              dig_val   = {6'd0, c[2:0]};
              oct_count = 2'd1;
            end else begin
              push_token(KIND_CHAR, c, 64'd0);
            end
          end
        endcase
      end
      MODE_HEX0: begin
        if (h >= 0) begin
          dig_val   = 9'(h);
          esc_state = MODE_HEX1;
        end else begin
          esc_state = MODE_IDLE;
          if (c == CH_NUL) push_token(KIND_END, 8'd0, 64'd0);
          else push_token(KIND_CHAR, c, 64'd0);
        end
      end
      MODE_HEX1: begin
        esc_state = MODE_IDLE;
        if (h >= 0) begin
          push_token(KIND_CHAR, 8'((dig_val << 4) + 9'(h)), 64'd0);
        end else begin
          push_token(KIND_CHAR, dig_val[7:0], 64'd0);
          plain_byte(c);
        end
      end
      MODE_OCT: begin
        if (c >= CH_0 && c <= CH_7) begin
          dig_val   = (dig_val << 3) + {6'd0, c[2:0]};
          oct_count = oct_count + 2'd1;
          if (oct_count == 2'd3) begin
            esc_state = MODE_IDLE;
            push_token(KIND_CHAR, dig_val[7:0], 64'd0);
          end
        end else begin
          esc_state = MODE_IDLE;
          push_token(KIND_CHAR, dig_val[7:0], 64'd0);
          plain_byte(c);
        end
      end
      MODE_DELAY: begin
        if (c >= CH_0 && c <= CH_9) begin
          dly_val = clip_add(clip_mul(dly_val, 64'd10), {56'd0, c - CH_0});
        end else begin
          t = (dly_val == 0) ? 64'd1 : dly_val;
          k = dly_wait ? KIND_WAIT : KIND_DELAY;
          esc_state = MODE_IDLE;
          if (c == CH_LM) begin
            push_token(k, 8'd0, t);
          end else begin
            push_token(k, 8'd0, clip_mul(t, 64'd1000));
            if (c != CH_LS) plain_byte(c);
          end
        end
      end
      default: plain_byte(c);
    endcase
    if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
  endtask

  task automatic take_byte(input cmd_row_t row);
    result_t t;
    decode_byte(row.ch);
    bytes_sent++;
    if (row.typed) begin
      t.token_kind = row.kind;
      t.char_value = row.cv;
      t.delay_ms   = row.dl;
      t.last       = 1'b1;
      tokens_due.push_back(t);
    end else begin
      foreach (fresh[i]) tokens_due.push_back(fresh[i]);
    end
  endtask

  task automatic put(input logic [7:0] c);
    cmd_row_t row;
    row       = '0;
    row.ch    = c;
    row.kind  = KIND_CHAR;
    plan.push_back(row);
  endtask

  // one random piece of a command string
  task automatic add_random_piece();
    int unsigned sel, n, i;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      put(8'($urandom_range(0, 255)));
    end else if (sel < 25) begin
      put(CH_NUL);
    end else if (sel < 40) begin
      put(CH_BACKSLASH);
      put(ESC_CHARS[$urandom_range(0, ESC_CHARS.len() - 1)]);
    end else if (sel < 48) begin
      put(CH_BACKSLASH);
      put(($urandom_range(0, 7) == 0) ? CH_BACKSLASH : 8'($urandom_range(0, 255)));
    end else if (sel < 60) begin
      put(CH_BACKSLASH);
      put(CH_LX);
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) put(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)]);
      if ($urandom_range(0, 1) == 0) put(8'($urandom_range(0, 255)));
    end else if (sel < 72) begin
      put(CH_BACKSLASH);
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) put(CH_0 + 8'($urandom_range(0, 7)));
    end else if (sel < 95) begin
      put(CH_BACKSLASH);
      put(($urandom_range(0, 1) == 0) ? CH_LD : CH_LW);
      case ($urandom_range(0, 7))
        0:       n = $urandom_range(10, 12);
        1:       n = 7;
        default: n = $urandom_range(0, 4);
      endcase
      for (i = 0; i < n; i++) begin
        if (i == 0 && n >= 7) put(CH_0 + 8'($urandom_range(4, 9)));
        else put(CH_0 + 8'($urandom_range(0, 9)));
      end
      case ($urandom_range(0, 3))
        0: put(CH_LM);
        1: put(CH_LS);
        2: ;
        default: put(8'($urandom_range(0, 255)));
      endcase
    end else begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
    end
  endtask

  // sender
  initial begin : stimulus
    int unsigned idx, burst_left, gap;
    cmd_row_t    row;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    rst      <= 1'b1;
    for (idx = 0; idx < DIR_N; idx++) plan.push_back(DIR_TAB[idx]);
    while (plan.size() < DIR_N + RAND_ITEMS) add_random_piece();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = 0;
    for (idx = 0; idx < plan.size(); idx++) begin
      row = plan[idx];
      if (idx == DIR_N + 400) hold_req = 1'b1;
      s_tvalid <= 1'b1;
      s_tdata  <= row.ch;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      take_byte(row);
      if (burst_left != 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d command bytes; checked chars %0d, ends %0d, delays %0d, sends %0d, waits %0d",
             bytes_sent, kind_seen[KIND_CHAR], kind_seen[KIND_END], kind_seen[KIND_DELAY],
             kind_seen[KIND_SEND], kind_seen[KIND_WAIT]);
    $display("saturated delay/wait tokens %0d; one output hold-off of %0d cycles",
             sat_delays, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // receiver
  initial begin : sink
    int unsigned style, run;
    logic        rdy;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end
      style = $urandom_range(0, 3);
      run   = $urandom_range(10, 60);
      repeat (run) begin
        case (style)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 1) == 0);
          2:       rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ~m_tready;
        endcase
        m_tready <= rdy;
        @(posedge clk);
      end
    end
  end

  // output checker
  result_t due;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction tdata=%h tlast=%b", m_tdata, m_tlast));
      end else begin
        due = tokens_due.pop_front();
        if (m_tdata[2:0] != due.token_kind)
          report_mismatch($sformatf("token_kind %0d, want %0d", m_tdata[2:0], due.token_kind));
        if (m_tdata[10:3] != due.char_value)
          report_mismatch($sformatf("char_value %h, want %h", m_tdata[10:3], due.char_value));
        if (m_tdata[42:11] != due.delay_ms)
          report_mismatch($sformatf("delay_ms %0d, want %0d", m_tdata[42:11], due.delay_ms));
        if (m_tlast != due.last)
          report_mismatch($sformatf("tlast %b, want %b", m_tlast, due.last));
        if (m_tdata[47:43] != '0)
          report_mismatch($sformatf("pad bits %b not zero", m_tdata[47:43]));
        if (due.token_kind <= KIND_WAIT) kind_seen[due.token_kind]++;
        if ((due.token_kind == KIND_DELAY || due.token_kind == KIND_WAIT) &&
            due.delay_ms == 32'hffff_ffff)
          sat_delays++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule
